/* rtl/core/peak_interval_histogram_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the peak interval histogram core.
// The modules that use them have clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef PEAK_INTERVAL_HISTOGRAM_CORE_DEFINES_SVH
`define PEAK_INTERVAL_HISTOGRAM_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define PIH_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define PIH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/pih_pkg.sv */
// ----------------------------------------------------------------------------
// pih_pkg
// Types, sizes and codes shared by the peak interval histogram core.
// ----------------------------------------------------------------------------
package pih_pkg;

	// Histogram and sample sizing
	localparam int HIST_BINS   = 1024;
	localparam int SAMPLE_BITS = 16;
	localparam int ADDR_W      = $clog2(HIST_BINS);

	// Fixed field widths of the interface
	localparam int SAMPLE_FIELD_W = 16;
	localparam int BIN_FIELD_W    = 10;
	localparam int SPACING_W      = 10;
	localparam int COUNT_W        = 32;
	localparam int INDEX_W        = 32;

	// Buffer depths
	localparam int QUEUE_DEPTH = 4;
	localparam int OUT_DEPTH   = 4;

	typedef logic signed [SAMPLE_BITS-1:0] samp_t;
	typedef logic [ADDR_W-1:0]             addr_t;
	typedef logic [COUNT_W-1:0]            count_t;
	typedef logic [INDEX_W-1:0]            index_t;

	// Command codes
	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_START  = 2'd1,
		CMD_READ   = 2'd2,
		CMD_ZERO   = 2'd3
	} cmd_t;

	// Histogram operations handed from front to back
	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_TALLY = 2'd1,
		OP_READ  = 2'd2,
		OP_ZERO  = 2'd3
	} op_kind_t;

	typedef struct packed {
		cmd_t                             cmd;
		logic signed [SAMPLE_FIELD_W-1:0] sample;
		logic [BIN_FIELD_W-1:0]           bin;
	} item_t;

	typedef struct packed {
		logic                 is_max_peak;
		logic                 is_min_peak;
		logic [SPACING_W-1:0] max_spacing;
		logic [SPACING_W-1:0] min_spacing;
		logic                 spacing_clipped;
		count_t               max_bin_count;
		count_t               min_bin_count;
	} result_t;

	typedef struct packed {
		op_kind_t             kind;
		logic                 max_en;
		logic                 min_en;
		addr_t                max_addr;
		addr_t                min_addr;
		logic                 is_max_peak;
		logic                 is_min_peak;
		logic [SPACING_W-1:0] max_spacing;
		logic [SPACING_W-1:0] min_spacing;
		logic                 spacing_clipped;
	} op_t;

endpackage

/* rtl/core/pih_ram.sv */
// ----------------------------------------------------------------------------
// pih_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pih_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and read; a read of the address being written returns old data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/pih_front.sv */
// ----------------------------------------------------------------------------
// pih_front
// Accepts commands, tracks the three-sample window and last peak positions,
// and turns each item into one histogram operation for the back end.
// ----------------------------------------------------------------------------
`include "peak_interval_histogram_core_defines.svh"

module pih_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  pih_pkg::item_t  item,
	input  logic            clearing,
	output logic            op_valid,
	input  logic            op_ready,
	output pih_pkg::op_t    op
);

	pih_pkg::samp_t  older_q, newer_q, samp;
	pih_pkg::index_t idx_q, last_max_q, last_min_q, mid, max_dist, min_dist;
	logic            max_seen_q, min_seen_q;
	logic            accept, tested, is_max, is_min, max_en, min_en;
	logic            max_over, min_over, in_range;
	pih_pkg::addr_t  max_bin, min_bin, bin_addr;

	assign item_ready = op_ready && !clearing;
	assign op_valid   = item_valid && !clearing;
	assign accept     = item_valid && item_ready;

	// Peak tests and spacings for the middle sample of the window
	always_comb begin
		samp     = pih_pkg::SAMPLE_BITS'($unsigned(item.sample));
		tested   = idx_q >= pih_pkg::INDEX_W'(2);
		mid      = idx_q - pih_pkg::INDEX_W'(1);
		is_max   = tested && (newer_q >= older_q) && (newer_q >= samp);
		is_min   = tested && (newer_q < older_q) && (newer_q < samp);
		max_dist = mid - last_max_q;
		min_dist = mid - last_min_q;
		max_over = max_dist > pih_pkg::INDEX_W'(pih_pkg::HIST_BINS - 1);
		min_over = min_dist > pih_pkg::INDEX_W'(pih_pkg::HIST_BINS - 1);
		max_bin  = max_over ? pih_pkg::ADDR_W'(pih_pkg::HIST_BINS - 1)
		                    : max_dist[pih_pkg::ADDR_W-1:0];
		min_bin  = min_over ? pih_pkg::ADDR_W'(pih_pkg::HIST_BINS - 1)
		                    : min_dist[pih_pkg::ADDR_W-1:0];
		max_en   = is_max && max_seen_q;
		min_en   = is_min && min_seen_q;
		in_range = 32'(item.bin) < 32'(pih_pkg::HIST_BINS);
		bin_addr = pih_pkg::ADDR_W'(item.bin);
	end

	// Operation for the back end
	always_comb begin
		op = '0;
		unique case (item.cmd)
			pih_pkg::CMD_SAMPLE: begin
				op.kind            = (max_en || min_en) ? pih_pkg::OP_TALLY : pih_pkg::OP_NONE;
				op.max_en          = max_en;
				op.min_en          = min_en;
				op.max_addr        = max_bin;
				op.min_addr        = min_bin;
				op.is_max_peak     = is_max;
				op.is_min_peak     = is_min;
				op.max_spacing     = max_en ? pih_pkg::SPACING_W'(max_bin) : '0;
				op.min_spacing     = min_en ? pih_pkg::SPACING_W'(min_bin) : '0;
				op.spacing_clipped = (max_en && max_over) || (min_en && min_over);
			end
			pih_pkg::CMD_START: begin
				op.kind = pih_pkg::OP_NONE;
			end
			pih_pkg::CMD_READ: begin
				op.kind     = pih_pkg::OP_READ;
				op.max_en   = in_range;
				op.min_en   = in_range;
				op.max_addr = bin_addr;
				op.min_addr = bin_addr;
			end
			pih_pkg::CMD_ZERO: begin
				op.kind     = pih_pkg::OP_ZERO;
				op.max_en   = in_range;
				op.min_en   = in_range;
				op.max_addr = bin_addr;
				op.min_addr = bin_addr;
			end
		endcase
	end

	// Record state: sample window, index and last peak positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q    <= '0;
			newer_q    <= '0;
			idx_q      <= '0;
			max_seen_q <= 1'b0;
			last_max_q <= '0;
			min_seen_q <= 1'b0;
			last_min_q <= '0;
		end else if (accept) begin
			unique case (item.cmd)
				pih_pkg::CMD_SAMPLE: begin
					older_q <= newer_q;
					newer_q <= samp;
					idx_q   <= idx_q + pih_pkg::INDEX_W'(1);
					if (is_max) begin
						max_seen_q <= 1'b1;
						last_max_q <= mid;
					end
					if (is_min) begin
						min_seen_q <= 1'b1;
						last_min_q <= mid;
					end
				end
				pih_pkg::CMD_START: begin
					older_q    <= '0;
					newer_q    <= '0;
					idx_q      <= '0;
					max_seen_q <= 1'b0;
					last_max_q <= '0;
					min_seen_q <= 1'b0;
					last_min_q <= '0;
				end
				pih_pkg::CMD_READ, pih_pkg::CMD_ZERO: begin
				end
			endcase
		end
	end

	// A start command leaves an empty record behind
	`PIH_ASSERT_NEXT(a_start_clears, accept && item.cmd == pih_pkg::CMD_START, idx_q == '0 && !max_seen_q && !min_seen_q, "start command did not clear the record")

endmodule

/* rtl/core/pih_queue.sv */
// ----------------------------------------------------------------------------
// pih_queue
// Short FIFO of histogram operations between the front and back ends.
// ----------------------------------------------------------------------------
`include "peak_interval_histogram_core_defines.svh"

module pih_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  pih_pkg::op_t push_op,
	output logic         pop_valid,
	input  logic         pop_ready,
	output pih_pkg::op_t pop_op
);

	localparam int PTR_W = $clog2(pih_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(pih_pkg::QUEUE_DEPTH + 1);

	pih_pkg::op_t     entry_q [pih_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push, pop;

	assign push_ready = cnt_q != CNT_W'(pih_pkg::QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_op     = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(pih_pkg::QUEUE_DEPTH - 1)) ? '0
				            : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(pih_pkg::QUEUE_DEPTH - 1)) ? '0
				            : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Fill count follows the transfers
	`PIH_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_q == $past(cnt_q) + CNT_W'(1), "queue count did not rise on push")
	`PIH_ASSERT_NEXT(a_cnt_down, pop && !push, cnt_q == $past(cnt_q) - CNT_W'(1), "queue count did not fall on pop")

endmodule

/* rtl/core/pih_back.sv */
// ----------------------------------------------------------------------------
// pih_back
// Histogram engine: clears both histograms after reset, reads each op's bins,
// writes back tallies and zeros with write forwarding, and buffers results.
// ----------------------------------------------------------------------------
`include "peak_interval_histogram_core_defines.svh"

module pih_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             op_valid,
	output logic             op_ready,
	input  pih_pkg::op_t     op,
	output logic             clearing,
	output logic             result_valid,
	input  logic             result_ready,
	output pih_pkg::result_t result
);

	localparam int OPTR_W = $clog2(pih_pkg::OUT_DEPTH);
	localparam int OCNT_W = $clog2(pih_pkg::OUT_DEPTH + 1);

	logic               clearing_q;
	pih_pkg::addr_t     clr_addr_q;
	logic               valid_s1;
	pih_pkg::op_t       op_s1;
	pih_pkg::count_t    rd_max, rd_min, old_max, old_min, new_max, new_min;
	logic               we_max, we_min, writes;
	pih_pkg::addr_t     wa_max, wa_min;
	pih_pkg::count_t    wd_max, wd_min;
	logic               fwd_max_v_q, fwd_min_v_q;
	pih_pkg::addr_t     fwd_max_addr_q, fwd_min_addr_q;
	pih_pkg::count_t    fwd_max_data_q, fwd_min_data_q;
	pih_pkg::result_t   res_s1;
	pih_pkg::result_t   out_q [pih_pkg::OUT_DEPTH];
	logic [OPTR_W-1:0]  out_wr_q, out_rd_q;
	logic [OCNT_W-1:0]  out_cnt_q;
	logic               issue, out_pop;

	// Issue only when the result buffer has room for everything in flight
	assign clearing = clearing_q;
	assign op_ready = !clearing_q
	                  && (out_cnt_q + OCNT_W'(valid_s1) < OCNT_W'(pih_pkg::OUT_DEPTH));
	assign issue    = op_valid && op_ready;

	// Histogram memories
	pih_ram #(
		.WIDTH(pih_pkg::COUNT_W),
		.DEPTH(pih_pkg::HIST_BINS)
	) u_max_hist (
		.clk  (clk),
		.we   (we_max),
		.waddr(wa_max),
		.wdata(wd_max),
		.raddr(op.max_addr),
		.rdata(rd_max)
	);

	pih_ram #(
		.WIDTH(pih_pkg::COUNT_W),
		.DEPTH(pih_pkg::HIST_BINS)
	) u_min_hist (
		.clk  (clk),
		.we   (we_min),
		.waddr(wa_min),
		.wdata(wd_min),
		.raddr(op.min_addr),
		.rdata(rd_min)
	);

	// Read data with forwarding of the write done at the read edge
	always_comb begin
		old_max = (fwd_max_v_q && fwd_max_addr_q == op_s1.max_addr) ? fwd_max_data_q : rd_max;
		old_min = (fwd_min_v_q && fwd_min_addr_q == op_s1.min_addr) ? fwd_min_data_q : rd_min;
		new_max = (op_s1.kind == pih_pkg::OP_ZERO) ? '0
		          : ((&old_max) ? old_max : old_max + pih_pkg::COUNT_W'(1));
		new_min = (op_s1.kind == pih_pkg::OP_ZERO) ? '0
		          : ((&old_min) ? old_min : old_min + pih_pkg::COUNT_W'(1));
	end

	// Write port: clearing sweep, or tally and zero operations
	always_comb begin
		writes = op_s1.kind == pih_pkg::OP_TALLY || op_s1.kind == pih_pkg::OP_ZERO;
		we_max = clearing_q || (valid_s1 && op_s1.max_en && writes);
		we_min = clearing_q || (valid_s1 && op_s1.min_en && writes);
		wa_max = clearing_q ? clr_addr_q : op_s1.max_addr;
		wa_min = clearing_q ? clr_addr_q : op_s1.min_addr;
		wd_max = clearing_q ? '0 : new_max;
		wd_min = clearing_q ? '0 : new_min;
	end

	// Result of the operation in stage one
	always_comb begin
		res_s1.is_max_peak     = op_s1.is_max_peak;
		res_s1.is_min_peak     = op_s1.is_min_peak;
		res_s1.max_spacing     = op_s1.max_spacing;
		res_s1.min_spacing     = op_s1.min_spacing;
		res_s1.spacing_clipped = op_s1.spacing_clipped;
		res_s1.max_bin_count   = (op_s1.kind == pih_pkg::OP_READ && op_s1.max_en) ? old_max : '0;
		res_s1.min_bin_count   = (op_s1.kind == pih_pkg::OP_READ && op_s1.min_en) ? old_min : '0;
	end

	// Clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			if (clr_addr_q == pih_pkg::ADDR_W'(pih_pkg::HIST_BINS - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + pih_pkg::ADDR_W'(1);
		end
	end

	// Stage one control and forwarding valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_max_v_q <= 1'b0;
			fwd_min_v_q <= 1'b0;
		end else begin
			valid_s1    <= issue;
			fwd_max_v_q <= we_max && !clearing_q;
			fwd_min_v_q <= we_min && !clearing_q;
		end
	end

	// Stage one payload and forwarding data
	always_ff @(posedge clk) begin
		if (issue) begin
			op_s1 <= op;
		end
		fwd_max_addr_q <= wa_max;
		fwd_min_addr_q <= wa_min;
		fwd_max_data_q <= wd_max;
		fwd_min_data_q <= wd_min;
	end

	// Result buffer
	assign result_valid = out_cnt_q != '0;
	assign result       = out_q[out_rd_q];
	assign out_pop      = result_valid && result_ready;

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			out_q[out_wr_q] <= res_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q  <= '0;
			out_rd_q  <= '0;
			out_cnt_q <= '0;
		end else begin
			if (valid_s1) begin
				out_wr_q <= (out_wr_q == OPTR_W'(pih_pkg::OUT_DEPTH - 1)) ? '0
				            : out_wr_q + OPTR_W'(1);
			end
			if (out_pop) begin
				out_rd_q <= (out_rd_q == OPTR_W'(pih_pkg::OUT_DEPTH - 1)) ? '0
				            : out_rd_q + OPTR_W'(1);
			end
			if (valid_s1 && !out_pop) begin
				out_cnt_q <= out_cnt_q + OCNT_W'(1);
			end else if (out_pop && !valid_s1) begin
				out_cnt_q <= out_cnt_q - OCNT_W'(1);
			end
		end
	end

	// No operation reaches stage one while the sweep runs
	`PIH_ASSERT_NEXT(a_no_issue_clear, clearing_q, !valid_s1, "operation issued during clearing")
	// Credit keeps the result buffer from overflowing
	`PIH_ASSERT_IMP(a_out_room, valid_s1, out_cnt_q < OCNT_W'(pih_pkg::OUT_DEPTH), "result buffer overflow")
	// Counts come back only for read operations
	`PIH_ASSERT_IMP(a_counts_read_only, valid_s1 && op_s1.kind != pih_pkg::OP_READ, res_s1.max_bin_count == '0 && res_s1.min_bin_count == '0, "count on a non-read result")

endmodule

/* rtl/core/peak_interval_histogram_core.sv */
// ----------------------------------------------------------------------------
// peak_interval_histogram_core
// Usage:
//   item channel (item_valid/item_ready/item) takes one command per transfer:
//   a sample, a record start, a bin read or a bin zero. result channel
//   (result_valid/result_ready/result) returns exactly one result per item,
//   in order: peak flags, spacings and clip flag for samples, both bin counts
//   for reads, all zero otherwise.
//   Path: each item passes the operation queue, stage one and the result
//   buffer before result_valid rises. Throughput: one item per cycle unless
//   a sweep or receiver stall holds it, set by the single read-modify-write
//   per histogram memory per cycle (forwarded when the same bin repeats).
//   Reset: record state clears at once; both histogram memories are then
//   swept to zero, one bin per cycle over all HIST_BINS (1024) bins;
//   item_ready stays low during the sweep.
//   Receiver stall: results collect in a four-entry buffer and then in the
//   four-entry operation queue; item_ready falls once both are full.
// ----------------------------------------------------------------------------
module peak_interval_histogram_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  pih_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output pih_pkg::result_t result
);

	logic         clearing;
	logic         push_valid, push_ready, pop_valid, pop_ready;
	pih_pkg::op_t push_op, pop_op;

	// Front end: record tracking and classification
	pih_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item),
		.clearing  (clearing),
		.op_valid  (push_valid),
		.op_ready  (push_ready),
		.op        (push_op)
	);

	// Operation queue
	pih_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_op   (push_op),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_op    (pop_op)
	);

	// Back end: histogram memories and result buffer
	pih_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.op_valid    (pop_valid),
		.op_ready    (pop_ready),
		.op          (pop_op),
		.clearing    (clearing),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

endmodule
